/* rtl/sedf_pkg.sv */
// Shared constants, queue entry type and CRC helpers for the STX/ETX DLE framer.
// No dependencies; imported by all framer modules.
package sedf_pkg;

   localparam logic [7:0]  CH_STX   = 8'h02;
   localparam logic [7:0]  CH_ETX   = 8'h03;
   localparam logic [7:0]  CH_DLE   = 8'h10;
   localparam logic [7:0]  CH_XON   = 8'h11;
   localparam logic [7:0]  CH_XOFF  = 8'h13;
   localparam logic [7:0]  ESC_OR   = 8'h40;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // One classified payload byte, handed from front end to back end.
   typedef struct packed {
      logic [7:0]  data;
      logic        open_frame;   // emit STX ahead of the byte
      logic        close_frame;  // emit CRC and ETX after the byte
      logic [15:0] crc;          // CRC including this byte
   } entry_type;

   // CRC-16 CCITT, MSB first, one byte
   function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] c);
      logic [15:0] r;
      r = crc ^ {c, 8'h00};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   localparam logic [15:0] CRC_SEED = crc_add(16'h0000, CH_STX);

   function automatic logic needs_esc(logic [7:0] b);
      return (b == CH_STX) || (b == CH_ETX) || (b == CH_DLE) ||
             (b == CH_XON) || (b == CH_XOFF);
   endfunction

endpackage

/* rtl/stx_etx_dle_framer_crc16.sv */
// STX/ETX framer with DLE stuffing and CRC-16 CCITT; top level.
// A request passes the FIFO, the back-end entry register and the output register.
// Throughput: one line byte per cycle from the back-end serializer unless rsp_tready is
// low; a request yields 1 to 8 line bytes and queues in a FIFO_DEPTH-entry buffer.
// Reset (synchronous, active high): CRC cleared, no frame open, queue and output empty.
module stx_etx_dle_framer_crc16 #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tlast,   // end_of_command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] line_byte
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // frame_done
);
   import sedf_pkg::*;

   logic      q_ready;
   logic      q_push;
   entry_type q_entry;
   logic      q_pop;
   entry_type q_head;
   logic      q_valid;

   sedf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   sedf_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .ready      (q_ready),
      .pop        (q_pop),
      .head       (q_head),
      .valid      (q_valid)
   );

   sedf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/sedf_front.sv */
// Front end: accepts payload requests, tracks frame state and running CRC.
// Depends on sedf_pkg; pushes classified entries into sedf_fifo.
module sedf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] payload_byte
   input  logic                 req_tlast,   // end_of_command
   input  logic                 q_ready,
   output logic                 q_push,
   output sedf_pkg::entry_type  q_entry
);
   import sedf_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic        open_ff, open_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic        accept;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;
   assign crc_base   = open_ff ? crc_ff : CRC_SEED;
   assign crc_next   = crc_add(crc_base, req_tdata);

   always_comb begin
      q_push              = accept;
      q_entry.data        = req_tdata;
      q_entry.open_frame  = !open_ff;
      q_entry.close_frame = req_tlast;
      q_entry.crc         = crc_next;
      crc_in              = crc_ff;
      open_in             = open_ff;
      if (accept) begin
         crc_in  = req_tlast ? 16'h0000 : crc_next;
         open_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= 16'h0000;
         open_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         open_ff <= open_in;
      end
   end

endmodule

/* rtl/sedf_fifo.sv */
// Short queue of classified entries between front end and back end.
// Depends on sedf_pkg for the entry type.
module sedf_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sedf_pkg::entry_type  push_entry,
   output logic                 ready,
   input  logic                 pop,
   output sedf_pkg::entry_type  head,
   output logic                 valid
);
   import sedf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign ready   = (count_ff != CW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && ready;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/sedf_back.sv */
// Back end: expands each entry into line bytes (STX, escaped data, CRC, ETX).
// Depends on sedf_pkg; drives the registered response channel.
module sedf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  sedf_pkg::entry_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] line_byte
   output logic                 rsp_tlast,   // last_of_run
   output logic                 rsp_tuser    // frame_done
);
   import sedf_pkg::*;

   localparam logic [2:0] PH_STX  = 3'd0;
   localparam logic [2:0] PH_DATA = 3'd1;
   localparam logic [2:0] PH_CRCH = 3'd2;
   localparam logic [2:0] PH_CRCL = 3'd3;
   localparam logic [2:0] PH_ETX  = 3'd4;

   entry_type   ent_ff, ent_in;
   logic        busy_ff, busy_in;
   logic [2:0]  phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic        vld_ff, vld_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;

   logic [7:0]  cur_byte;
   logic        escapable;
   logic [7:0]  emit_byte;
   logic        esc_next;
   logic        advance;
   logic        finish;
   logic [2:0]  phase_next;
   logic        step;
   logic        load;

   always_comb begin
      cur_byte   = ent_ff.data;
      escapable  = 1'b1;
      phase_next = PH_ETX;
      unique case (phase_ff)
         PH_STX: begin
            cur_byte   = CH_STX;
            escapable  = 1'b0;
            phase_next = PH_DATA;
         end
         PH_DATA: begin
            cur_byte   = ent_ff.data;
            phase_next = PH_CRCH;
         end
         PH_CRCH: begin
            cur_byte   = ent_ff.crc[15:8];
            phase_next = PH_CRCL;
         end
         PH_CRCL: begin
            cur_byte   = ent_ff.crc[7:0];
            phase_next = PH_ETX;
         end
         PH_ETX: begin
            cur_byte   = CH_ETX;
            escapable  = 1'b0;
            phase_next = PH_ETX;
         end
         default: begin
            cur_byte   = CH_ETX;
            escapable  = 1'b0;
            phase_next = PH_ETX;
         end
      endcase

      // first half of an escape sends DLE and holds the phase
      if (!esc_ff && escapable && needs_esc(cur_byte)) begin
         emit_byte = CH_DLE;
         esc_next  = 1'b1;
         advance   = 1'b0;
      end else begin
         emit_byte = esc_ff ? (cur_byte | ESC_OR) : cur_byte;
         esc_next  = 1'b0;
         advance   = 1'b1;
      end

      finish = advance && (((phase_ff == PH_DATA) && !ent_ff.close_frame) ||
                           (phase_ff == PH_ETX));
      step   = busy_ff && (!vld_ff || rsp_tready);
      load   = (!busy_ff || (step && finish)) && q_valid;
      q_pop  = load;

      busy_in  = busy_ff;
      ent_in   = ent_ff;
      phase_in = phase_ff;
      esc_in   = esc_ff;
      if (load) begin
         busy_in  = 1'b1;
         ent_in   = q_head;
         phase_in = q_head.open_frame ? PH_STX : PH_DATA;
         esc_in   = 1'b0;
      end else if (step) begin
         esc_in = esc_next;
         if (finish) begin
            busy_in = 1'b0;
         end else if (advance) begin
            phase_in = phase_next;
         end
      end

      vld_in  = vld_ff;
      data_in = data_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (step) begin
         vld_in  = 1'b1;
         data_in = emit_byte;
         last_in = finish;
         done_in = advance && (phase_ff == PH_ETX);
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      data_ff <= data_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_STX;
         esc_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

/* tb/tb_stx_etx_dle_framer_crc16.sv */
// Self-checking testbench for stx_etx_dle_framer_crc16: STX/ETX framing, DLE stuffing, CRC-16.
// Directed table then random commands; each line byte checked against table or in-bench model.
// Depends on rtl/sedf_pkg.sv (constants) and rtl/stx_etx_dle_framer_crc16.sv.
module tb_stx_etx_dle_framer_crc16;
   timeunit 1ns;
   timeprecision 1ps;
   import sedf_pkg::*;

   localparam int RANDOM_ITEMS = 420;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       last_of_run;
      logic       frame_done;
   } line_type;

   // n_typed == 0: row checked against the model, else t0/t1 are the expected line bytes
   typedef struct packed {
      logic [7:0] payload;
      logic       eoc;
      logic [1:0] n_typed;
      logic [7:0] t0;
      logic [7:0] t1;
   } cmd_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] payload_byte
   logic       req_tlast;   // end_of_command
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // [7:0] line_byte
   logic       rsp_tlast;   // last_of_run
   logic       rsp_tuser;   // frame_done

   stx_etx_dle_framer_crc16 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // framer model state
   logic [15:0] crc_acc;
   logic        in_frame;
   line_type    frame_buf [8];
   int          frame_cnt;
   line_type    pending_line [$];

   int mismatches  = 0;
   int cycle_count = 0;
   int burst_left  = 0;

   cmd_row_type dir_rows [22] = '{
      '{8'h41, 1'b0, 2'd2, CH_STX, 8'h41},            // opens a frame
      '{CH_STX, 1'b0, 2'd2, CH_DLE, CH_STX | ESC_OR},
      '{CH_ETX, 1'b0, 2'd2, CH_DLE, CH_ETX | ESC_OR},
      '{CH_DLE, 1'b0, 2'd2, CH_DLE, CH_DLE | ESC_OR},
      '{CH_XON, 1'b0, 2'd2, CH_DLE, CH_XON | ESC_OR},
      '{CH_XOFF, 1'b0, 2'd2, CH_DLE, CH_XOFF | ESC_OR},
      '{8'h12, 1'b0, 2'd1, 8'h12, 8'h00},
      '{8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
      '{8'hFF, 1'b0, 2'd1, 8'hFF, 8'h00},
      '{8'h42, 1'b0, 2'd1, 8'h42, 8'h00},
      '{8'h7E, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h55, 1'b1, 2'd0, 8'h00, 8'h00},            // single-byte commands
      '{8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'hFF, 1'b1, 2'd0, 8'h00, 8'h00},
      '{CH_STX, 1'b1, 2'd0, 8'h00, 8'h00},
      '{CH_DLE, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h80, 1'b0, 2'd2, CH_STX, 8'h80},
      '{8'h01, 1'b0, 2'd1, 8'h01, 8'h00},
      '{8'h04, 1'b0, 2'd1, 8'h04, 8'h00},
      '{8'h0F, 1'b0, 2'd1, 8'h0F, 8'h00},
      '{8'h14, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'hAA, 1'b1, 2'd0, 8'h00, 8'h00}
   };

   function automatic logic is_ctrl(logic [7:0] b);
      case (b)
         CH_STX, CH_ETX, CH_DLE, CH_XON, CH_XOFF: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // bit-serial CCITT, MSB first
   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   task automatic put_line(logic [7:0] b, logic done);
      frame_buf[frame_cnt] = '{b, 1'b0, done};
      frame_cnt++;
   endtask

   task automatic put_stuffed(logic [7:0] b);
      if (is_ctrl(b)) begin
         put_line(CH_DLE, 1'b0);
         put_line(b | ESC_OR, 1'b0);
      end else begin
         put_line(b, 1'b0);
      end
   endtask

   // line bytes caused by one accepted request, into frame_buf
   task automatic frame_byte(logic [7:0] payload, logic eoc);
      frame_cnt = 0;
      if (!in_frame) begin
         put_line(CH_STX, 1'b0);
         crc_acc  = crc_step(16'h0000, CH_STX);
         in_frame = 1'b1;
      end
      put_stuffed(payload);
      crc_acc = crc_step(crc_acc, payload);
      if (eoc) begin
         put_stuffed(crc_acc[15:8]);
         put_stuffed(crc_acc[7:0]);
         put_line(CH_ETX, 1'b1);
         crc_acc  = 16'h0000;
         in_frame = 1'b0;
      end
      frame_buf[frame_cnt-1].last_of_run = 1'b1;
   endtask

   task automatic queue_predicted();
      for (int i = 0; i < frame_cnt; i++) pending_line.push_back(frame_buf[i]);
   endtask

   // returns at the edge where the request was taken
   task automatic send(logic [7:0] payload, logic eoc);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tlast  <= eoc;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_line.size() != 0);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] ctrl [5]  = '{CH_STX, CH_ETX, CH_DLE, CH_XON, CH_XOFF};
      logic [7:0] near [10] = '{8'h01, 8'h04, 8'h0F, 8'h12, 8'h14,
                                8'h42, 8'h43, 8'h50, 8'h51, 8'h53};
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return ctrl[$urandom_range(0, 4)];
      if (r == 3) return near[$urandom_range(0, 9)];
      return 8'($urandom);
   endfunction

   // closing byte that makes one of the CRC bytes need stuffing
   function automatic logic [7:0] crc_escaping_byte(logic [7:0] fallback);
      logic [15:0] start, c;
      logic [7:0]  off, cand;
      start = in_frame ? crc_acc : crc_step(16'h0000, CH_STX);
      off   = 8'($urandom);
      for (int i = 0; i < 256; i++) begin
         cand = off + 8'(i);
         c    = crc_step(start, cand);
         if (is_ctrl(c[15:8]) || is_ctrl(c[7:0])) return cand;
      end
      return fallback;
   endfunction

   function automatic logic ready_now(int cyc);
      case ((cyc >> 6) % 8)
         1: return $urandom_range(0, 3) != 0;
         2: return (cyc % 5) != 4;
         3: return $urandom_range(0, 3) == 0;
         4: return ((cyc >> 2) & 1) != 0;
         5: return $urandom_range(0, 1) != 0;
         default: return 1'b1;
      endcase
   endfunction

   task automatic note_mismatch(string what, line_type want, line_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected byte %h last %b done %b, got byte %h last %b done %b",
                  $realtime, what, want.line_byte, want.last_of_run, want.frame_done,
                  got.line_byte, got.last_of_run, got.frame_done);
   endtask

   always @(posedge clock) begin
      line_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tlast, rsp_tuser};
         if (pending_line.size() == 0) begin
            note_mismatch("line byte with nothing pending", '0, got);
         end else begin
            want = pending_line.pop_front();
            if (got !== want) note_mismatch("line byte mismatch", want, got);
         end
      end
      rsp_tready <= ready_now(cycle_count);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_stx_etx_dle_framer_crc16: errors");
      $finish;
   end

   initial begin
      int         frame_len, items, frames;
      logic       crafted, eoc;
      logic [7:0] b;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      crc_acc  = 16'h0000;
      in_frame = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send(dir_rows[i].payload, dir_rows[i].eoc);
         frame_byte(dir_rows[i].payload, dir_rows[i].eoc);
         if (dir_rows[i].n_typed == 0) begin
            queue_predicted();
         end else begin
            pending_line.push_back('{dir_rows[i].t0, dir_rows[i].n_typed == 1, 1'b0});
            if (dir_rows[i].n_typed == 2) pending_line.push_back('{dir_rows[i].t1, 1'b1, 1'b0});
         end
      end
      wait_idle();

      items  = 0;
      frames = 0;
      while (items < RANDOM_ITEMS) begin
         frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
         crafted   = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < frame_len; k++) begin
            eoc = (k == frame_len - 1);
            b   = pick_byte();
            if (eoc && crafted) b = crc_escaping_byte(b);
            send(b, eoc);
            frame_byte(b, eoc);
            queue_predicted();
            items++;
         end
         frames++;
         if (frames % 25 == 0) wait_idle();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_line.size() == 0)
         $display("tb_stx_etx_dle_framer_crc16: clean");
      else
         $display("tb_stx_etx_dle_framer_crc16: errors");
      $finish;
   end

endmodule
